>>> design/mcc_pkg.sv
// Shared types and constants for the minimum coin change block.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package mcc_pkg;

    localparam int AMT_W     = 10;
    localparam int COIN_W    = 10;
    localparam int CNT_W     = 11;
    localparam int NUM_COINS = 3;
    localparam int COIN_SEL_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int DEPTH     = 1 << AMT_W;

    // Table value that marks an amount no coin combination can make.
    localparam logic [CNT_W-1:0] NO_WAY = {CNT_W{1'b1}};

    typedef logic [COIN_W-1:0] coin_t;

    localparam coin_t COIN_RESET [NUM_COINS] = '{10'd1, 10'd3, 10'd4};

    localparam logic [COIN_SEL_W-1:0] LAST_COIN = COIN_SEL_W'(NUM_COINS - 1);

    typedef struct packed {
        logic start;
        logic init;
        logic run;
        logic drain;
        logic load_out;
    } mcc_cmd_t;

    typedef struct packed {
        logic last;
        logic amt_zero;
        logic out_free;
    } mcc_status_t;

endpackage

`default_nettype wire

>>> design/mcc_query_if.sv
// Query channel: one target amount per item.
// Depends on mcc_pkg for the field width.
`default_nettype none

interface mcc_query_if;
    logic                       valid;
    logic                       ready;
    logic [mcc_pkg::AMT_W-1:0]  amount;

    modport source (output valid, output amount, input ready);
    modport sink   (input valid, input amount, output ready);
endinterface

`default_nettype wire

>>> design/mcc_result_if.sv
// Result channel: fewest coin count and an unreachable flag per item.
// Depends on mcc_pkg for the field width.
`default_nettype none

interface mcc_result_if;
    logic                        valid;
    logic                        ready;
    logic [mcc_pkg::AMT_W-1:0]   coin_count;
    logic                        unreachable;

    modport source (output valid, output coin_count, output unreachable, input ready);
    modport sink   (input valid, input coin_count, input unreachable, output ready);
endinterface

`default_nettype wire

>>> design/mcc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on mcc_pkg for the field widths.
`default_nettype none

interface mcc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mcc_pkg::CFG_IDX_W-1:0]  index;
    logic [mcc_pkg::COIN_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/min_coin_change_top.sv
// Top level of the minimum coin change block: joins controller and datapath.
// Depends on mcc_pkg, the three channel interfaces, mcc_ctrl and mcc_dp.
`default_nettype none

// Each query item carries a target amount; the result item gives the fewest coins drawn with
// repetition from three denominations (reset 1, 3 and 4; the user must rewrite them through the
// cfg channel only while the block is idle, which the block does not enforce) that sum to it, or
// unreachable with count 0. The block rebuilds its count table from amount 1 up to the target for
// every query, trying one coin per cycle through the single read port of the table memory.
// Queries are worked one at a time; a new query is accepted as soon as the previous result has
// moved into the output register, and cfg writes are always taken.
module min_coin_change_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mcc_query_if.sink     query,
    mcc_result_if.source  result,
    mcc_cfg_if.sink       cfg
);

    mcc_pkg::mcc_cmd_t    cmd;
    mcc_pkg::mcc_status_t status;

    assign cfg.ready = 1'b1;

    mcc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query.valid),
        .query_ready (query.ready),
        .status      (status),
        .cmd         (cmd)
    );

    mcc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .amount          (query.amount),
        .cfg_valid       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_count       (result.coin_count),
        .out_unreachable (result.unreachable)
    );

    a_unreach_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.unreachable |-> result.coin_count == '0)
        else $error("unreachable result with nonzero coin count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        query.valid && query.ready |=> !query.ready)
        else $error("query accepted while previous query still in work");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result.valid || result.ready))
        else $error("result register overwritten before it was taken");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.init, cmd.run, cmd.drain, cmd.load_out}))
        else $error("controller issued more than one datapath command");

endmodule

`default_nettype wire

>>> design/mcc_ctrl.sv
// Controller state machine for the minimum coin change block.
// Depends on mcc_pkg for the command and status structs.
`default_nettype none

module mcc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 query_valid,
    output logic                      query_ready,
    input  wire mcc_pkg::mcc_status_t status,
    output mcc_pkg::mcc_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_valid)
                    state_next = ST_INIT;
            end
            ST_INIT:
            begin
                state_next = status.amt_zero ? ST_FINISH : ST_RUN;
            end
            ST_RUN:
            begin
                if (status.last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        query_ready  = (state_reg == ST_IDLE);
        cmd.start    = (state_reg == ST_IDLE) && query_valid;
        cmd.init     = (state_reg == ST_INIT);
        cmd.run      = (state_reg == ST_RUN);
        cmd.drain    = (state_reg == ST_DRAIN);
        cmd.load_out = (state_reg == ST_FINISH) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> design/mcc_dp.sv
// Datapath: coin registers, count table memory, read pipeline and result register.
// Depends on mcc_pkg; driven by mcc_ctrl through the command struct.
`default_nettype none

module mcc_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mcc_pkg::mcc_cmd_t                cmd,
    output mcc_pkg::mcc_status_t                  status,
    input  wire logic [mcc_pkg::AMT_W-1:0]        amount,
    input  wire logic                             cfg_valid,
    input  wire logic [mcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mcc_pkg::COIN_W-1:0]       cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [mcc_pkg::AMT_W-1:0]             out_count,
    output logic                                  out_unreachable
);

    mcc_pkg::coin_t                      coin_reg [mcc_pkg::NUM_COINS];
    logic [mcc_pkg::CNT_W-1:0]           mem [mcc_pkg::DEPTH];

    logic [mcc_pkg::AMT_W-1:0]           amount_reg;
    logic [mcc_pkg::AMT_W-1:0]           m_reg;
    logic [mcc_pkg::AMT_W-1:0]           m_next;
    logic [mcc_pkg::COIN_SEL_W-1:0]      phase_reg;
    logic [mcc_pkg::COIN_SEL_W-1:0]      phase_next;

    logic                                pipe_v_reg;
    logic                                pipe_ok_reg;
    logic [mcc_pkg::COIN_SEL_W-1:0]      pipe_slot_reg;
    logic [mcc_pkg::AMT_W-1:0]           pipe_m_reg;
    logic [mcc_pkg::CNT_W-1:0]           rd_q_reg;
    logic                                fwd_hit_reg;
    logic [mcc_pkg::CNT_W-1:0]           fwd_data_reg;
    logic [mcc_pkg::CNT_W-1:0]           acc_reg;
    logic [mcc_pkg::CNT_W-1:0]           acc_next;
    logic [mcc_pkg::CNT_W-1:0]           ans_reg;

    logic                                out_valid_reg;
    logic [mcc_pkg::AMT_W-1:0]           out_count_reg;
    logic                                out_unr_reg;

    mcc_pkg::coin_t                      sel_coin;
    logic                                coin_ok;
    logic [mcc_pkg::AMT_W-1:0]           rd_addr;
    logic [mcc_pkg::CNT_W-1:0]           prev;
    logic [mcc_pkg::CNT_W-1:0]           cand;
    logic [mcc_pkg::CNT_W-1:0]           final_best;
    logic                                wr_en;
    logic [mcc_pkg::AMT_W-1:0]           wr_addr;
    logic [mcc_pkg::CNT_W-1:0]           wr_data;

    // One coin is tried per cycle; a coin of zero or larger than the current table amount m is skipped.
    always_comb
    begin
        sel_coin = coin_reg[phase_reg];
        coin_ok  = (sel_coin != '0) && (sel_coin <= m_reg);
        rd_addr  = m_reg - sel_coin;
    end

    // The entry just below m is written in the same cycle its first read goes out,
    // so that read takes the write data instead of the stale memory word.
    always_comb
    begin
        prev = fwd_hit_reg ? fwd_data_reg : rd_q_reg;
        if (pipe_ok_reg && (prev != mcc_pkg::NO_WAY))
            cand = prev + 1'b1;
        else
            cand = mcc_pkg::NO_WAY;

        if (pipe_slot_reg == '0)
            acc_next = cand;
        else
            acc_next = (cand < acc_reg) ? cand : acc_reg;

        final_best = acc_next;

        wr_en   = cmd.init || (pipe_v_reg && (pipe_slot_reg == mcc_pkg::LAST_COIN));
        wr_addr = cmd.init ? '0 : pipe_m_reg;
        wr_data = cmd.init ? '0 : final_best;
    end

    always_comb
    begin
        m_next     = m_reg;
        phase_next = phase_reg;
        if (cmd.init)
        begin
            m_next     = mcc_pkg::AMT_W'(1);
            phase_next = '0;
        end
        else if (cmd.run)
        begin
            if (phase_reg == mcc_pkg::LAST_COIN)
            begin
                phase_next = '0;
                m_next     = m_reg + 1'b1;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        status.last     = (m_reg == amount_reg) && (phase_reg == mcc_pkg::LAST_COIN);
        status.amt_zero = (amount_reg == '0);
        status.out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcc_pkg::NUM_COINS; i++)
                coin_reg[i] <= mcc_pkg::COIN_RESET[i];
            m_reg         <= '0;
            phase_reg     <= '0;
            pipe_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index < mcc_pkg::CFG_IDX_W'(mcc_pkg::NUM_COINS)))
                coin_reg[cfg_index] <= cfg_data;
            m_reg      <= m_next;
            phase_reg  <= phase_next;
            pipe_v_reg <= cmd.run;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            amount_reg <= amount;
        pipe_ok_reg   <= coin_ok;
        pipe_slot_reg <= phase_reg;
        pipe_m_reg    <= m_reg;
        fwd_hit_reg   <= wr_en && (wr_addr == rd_addr);
        fwd_data_reg  <= wr_data;
        if (pipe_v_reg)
            acc_reg <= acc_next;
        if (cmd.init)
            ans_reg <= '0;
        else if (cmd.drain)
            ans_reg <= final_best;
        if (cmd.load_out)
        begin
            out_unr_reg   <= (ans_reg == mcc_pkg::NO_WAY);
            out_count_reg <= (ans_reg == mcc_pkg::NO_WAY) ? '0 : ans_reg[mcc_pkg::AMT_W-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_count       = out_count_reg;
    assign out_unreachable = out_unr_reg;

endmodule

`default_nettype wire
